### src/lmd_pkg.sv
// Package for the landmark map dedup block: widths, CORDIC constants, shared types.
// No dependencies.
`default_nettype none
package lmd_pkg;
	localparam int MaxLandmarks = 256;
	localparam int CoordWidth   = 24;
	localparam int AngleWidth   = 16;
	localparam int TolWidth     = 23;
	localparam int IdxWidth     = $clog2(MaxLandmarks);
	localparam int CntWidth     = $clog2(MaxLandmarks + 1);
	localparam int GuardBits    = 12;
	localparam int CordicSteps  = 16;
	localparam int StepWidth    = $clog2(CordicSteps);
	// rotation datapath: coordinate plus guard bits plus headroom for CORDIC gain
	localparam int RotWidth     = CoordWidth + GuardBits + 3;
	localparam int PhaseWidth   = 21;
	localparam int InvGain      = 39797;
	localparam int ProdWidth    = RotWidth + 17;

	typedef logic signed [CoordWidth-1:0] coord_t;

	typedef struct packed {
		logic load;      // capture input item, start rotation
		logic rot_step;  // one CORDIC iteration
		logic scale;     // gain multiply
		logic finish;    // round, add pose, saturate
		logic cmp_clr;   // clear duplicate flag
		logic cmp_step;  // compare one stored landmark
		logic append;    // write world point into store
		logic out_load;  // move result to output register
	} lmd_cmd_t;

	typedef struct packed {
		logic                 rot_last;
		logic                 cmp_last;
		logic                 store_full;
		logic                 dup;
	} lmd_sts_t;

	function automatic logic signed [PhaseWidth-1:0] atan_lut(input logic [StepWidth-1:0] i);
		logic signed [PhaseWidth-1:0] r;
		unique case (i)
			4'd0:  r = 21'sd131072;
			4'd1:  r = 21'sd77376;
			4'd2:  r = 21'sd40884;
			4'd3:  r = 21'sd20753;
			4'd4:  r = 21'sd10417;
			4'd5:  r = 21'sd5213;
			4'd6:  r = 21'sd2607;
			4'd7:  r = 21'sd1304;
			4'd8:  r = 21'sd652;
			4'd9:  r = 21'sd326;
			4'd10: r = 21'sd163;
			4'd11: r = 21'sd81;
			4'd12: r = 21'sd41;
			4'd13: r = 21'sd20;
			4'd14: r = 21'sd10;
			default: r = 21'sd5;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

### src/landmark_map_dedup.sv
// Top level of the landmark map dedup block: tolerance register, controller, datapath.
// Depends on lmd_pkg, lmd_ctrl, lmd_datapath.
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | point_x/y/z, pose_x/y, pose_yaw
//   out     | output    | out_valid/out_stall| world_x/y/z, is_new, dropped_full
//   cfg     | input     | tol_we             | tol_wdata (match_tolerance)
// An item runs 16 CORDIC iterations, gain multiply and pose add, then scans the N stored
// landmarks (N the number of stored landmarks), one store read per cycle.
// Reset clears the landmark count and sets the tolerance to 512; no clearing pass.
// The next item is taken while a finished result waits on out_stall.
`default_nettype none
module landmark_map_dedup import lmd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 tol_we,
	input  wire logic [TolWidth-1:0]  tol_wdata,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire coord_t               point_x,
	input  wire coord_t               point_y,
	input  wire coord_t               point_z,
	input  wire coord_t               pose_x,
	input  wire coord_t               pose_y,
	input  wire logic signed [AngleWidth-1:0] pose_yaw,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output coord_t                    world_x,
	output coord_t                    world_y,
	output coord_t                    world_z,
	output logic                      is_new,
	output logic                      dropped_full
);
	logic [TolWidth-1:0] tol_q;
	lmd_cmd_t cmd;
	lmd_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= TolWidth'(512);
		else if (tol_we)
			tol_q <= tol_wdata;
	end

	lmd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	lmd_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .tol(tol_q),
		.point_x, .point_y, .point_z, .pose_x, .pose_y, .pose_yaw,
		.world_x, .world_y, .world_z, .is_new, .dropped_full
	);
endmodule
`default_nettype wire

### src/lmd_datapath.sv
// Datapath: CORDIC rotation, pose add, landmark store and compare scan, result register.
// Depends on lmd_pkg.
`default_nettype none
module lmd_datapath import lmd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lmd_cmd_t             cmd,
	output lmd_sts_t                  sts,
	input  wire logic [TolWidth-1:0]  tol,
	input  wire coord_t               point_x,
	input  wire coord_t               point_y,
	input  wire coord_t               point_z,
	input  wire coord_t               pose_x,
	input  wire coord_t               pose_y,
	input  wire logic signed [AngleWidth-1:0] pose_yaw,
	output coord_t                    world_x,
	output coord_t                    world_y,
	output coord_t                    world_z,
	output logic                      is_new,
	output logic                      dropped_full
);
	logic signed [RotWidth-1:0]   x_q, y_q;
	logic signed [PhaseWidth-1:0] a_q;
	logic [StepWidth-1:0]         step_q;
	coord_t                       z_q, ox_q, oy_q, wx_q, wy_q;
	logic signed [ProdWidth-1:0]  px_q, py_q;
	logic [CntWidth-1:0]          count_q;
	logic [CntWidth-1:0]          scan_q;
	logic                         dup_q;
	logic [2*CoordWidth-1:0]      store [MaxLandmarks];
	logic [2*CoordWidth-1:0]      rd_q;
	logic                         rd_vld_q;

	// load-time quadrant fold
	logic signed [PhaseWidth-1:0] a_in;
	logic signed [RotWidth-1:0]   x_in, y_in;
	logic                         fold;
	always_comb begin
		a_in = PhaseWidth'(pose_yaw) <<< (20 - AngleWidth);
		x_in = RotWidth'(point_x) <<< GuardBits;
		y_in = RotWidth'(point_y) <<< GuardBits;
		fold = (a_in >= 21'sd262144) || (a_in < -21'sd262144);
	end

	logic signed [RotWidth-1:0] dx, dy;
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;

	// round, add pose, saturate
	localparam int SumWidth = ProdWidth - 28 + 2;
	logic signed [ProdWidth-1:0] rxf, ryf;
	logic signed [SumWidth-1:0]  sx, sy;
	coord_t                      satx, saty;
	localparam logic signed [SumWidth-1:0] Hi = SumWidth'((64'sd1 <<< (CoordWidth-1)) - 1);
	localparam logic signed [SumWidth-1:0] Lo = -Hi - 1;
	always_comb begin
		rxf = (px_q + (ProdWidth'(1) <<< 27)) >>> 28;
		ryf = (py_q + (ProdWidth'(1) <<< 27)) >>> 28;
		sx = SumWidth'(rxf) + SumWidth'(ox_q);
		sy = SumWidth'(ryf) + SumWidth'(oy_q);
		satx = (sx > Hi) ? coord_t'(Hi) : (sx < Lo) ? coord_t'(Lo) : coord_t'(sx);
		saty = (sy > Hi) ? coord_t'(Hi) : (sy < Lo) ? coord_t'(Lo) : coord_t'(sy);
	end

	// compare registered store entry against world point
	logic signed [CoordWidth:0] cdx, cdy;
	logic [CoordWidth:0]        adx, ady;
	logic                       hit;
	always_comb begin
		cdx = (CoordWidth+1)'(wx_q) - (CoordWidth+1)'($signed(rd_q[2*CoordWidth-1:CoordWidth]));
		cdy = (CoordWidth+1)'(wy_q) - (CoordWidth+1)'($signed(rd_q[CoordWidth-1:0]));
		adx = cdx[CoordWidth] ? (CoordWidth+1)'(-cdx) : (CoordWidth+1)'(cdx);
		ady = cdy[CoordWidth] ? (CoordWidth+1)'(-cdy) : (CoordWidth+1)'(cdy);
		hit = rd_vld_q && (adx < (CoordWidth+1)'(tol)) && (ady < (CoordWidth+1)'(tol));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q  <= fold ? (a_in[20] ? a_in + 21'sd524288 : a_in - 21'sd524288) : a_in;
			x_q  <= fold ? -x_in : x_in;
			y_q  <= fold ? -y_in : y_in;
			z_q  <= point_z;
			ox_q <= pose_x;
			oy_q <= pose_y;
		end else if (cmd.rot_step) begin
			if (!a_q[PhaseWidth-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				a_q <= a_q - atan_lut(step_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				a_q <= a_q + atan_lut(step_q);
			end
		end
		if (cmd.scale) begin
			px_q <= ProdWidth'(x_q) * ProdWidth'(InvGain);
			py_q <= ProdWidth'(y_q) * ProdWidth'(InvGain);
		end
		if (cmd.finish) begin
			wx_q <= satx;
			wy_q <= saty;
		end
		// hold the last entry while the result waits, so the decision stays put
		if (cmd.cmp_step)
			rd_q <= store[scan_q[IdxWidth-1:0]];
		if (cmd.append)
			store[count_q[IdxWidth-1:0]] <= {wx_q, wy_q};
		if (cmd.out_load) begin
			world_x <= wx_q;
			world_y <= wy_q;
			world_z <= z_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			count_q      <= '0;
			scan_q       <= '0;
			dup_q        <= 1'b0;
			rd_vld_q     <= 1'b0;
			is_new       <= 1'b0;
			dropped_full <= 1'b0;
		end else begin
			if (cmd.load)
				step_q <= '0;
			else if (cmd.rot_step)
				step_q <= step_q + 1'b1;
			if (cmd.cmp_clr) begin
				scan_q   <= '0;
				dup_q    <= 1'b0;
				rd_vld_q <= 1'b0;
			end else if (cmd.cmp_step) begin
				scan_q   <= scan_q + 1'b1;
				rd_vld_q <= 1'b1;
				if (hit)
					dup_q <= 1'b1;
			end
			if (cmd.append)
				count_q <= count_q + 1'b1;
			if (cmd.out_load) begin
				is_new       <= !sts.dup;
				dropped_full <= !sts.dup && sts.store_full;
			end
		end
	end

	always_comb begin
		sts.rot_last    = (step_q == StepWidth'(CordicSteps - 1));
		sts.cmp_last    = (scan_q == count_q);
		sts.store_full  = (count_q == CntWidth'(MaxLandmarks));
		sts.dup         = dup_q || hit;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntWidth'(MaxLandmarks)) else $error("landmark count overflow");
	a_no_append_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> !sts.store_full) else $error("append into full store");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |=> count_q == $past(count_q) + 1'b1) else $error("count did not advance");
endmodule
`default_nettype wire

### src/lmd_ctrl.sv
// Controller FSM: sequences rotation, store scan, append and output handshake.
// Depends on lmd_pkg.
`default_nettype none
module lmd_ctrl import lmd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire lmd_sts_t sts,
	output lmd_cmd_t      cmd
);
	typedef enum logic [2:0] {IDLE, ROT, SCALE, FIN, SCAN} state_t;
	state_t state_q;

	assign in_stall = (state_q != IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE:  cmd.load = in_valid;
			ROT:   cmd.rot_step = 1'b1;
			SCALE: cmd.scale = 1'b1;
			FIN:   begin cmd.finish = 1'b1; cmd.cmp_clr = 1'b1; end
			SCAN:  begin
				cmd.cmp_step = !sts.cmp_last;
				// last compared entry is in the read register; decide now
				if (sts.cmp_last && !(out_valid && out_stall)) begin
					cmd.out_load = 1'b1;
					cmd.append   = !sts.dup && !sts.store_full;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				IDLE:  if (in_valid) state_q <= ROT;
				ROT:   if (sts.rot_last) state_q <= SCALE;
				SCALE: state_q <= FIN;
				FIN:   state_q <= SCAN;
				SCAN:  if (cmd.out_load) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ROT) |-> in_stall) else $error("accepting while busy");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid) else $error("result not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall)) else $error("result overwritten");
endmodule
`default_nettype wire
